[design/pkl_pkg.sv]
// pkl_pkg: shared types, constants and register codes of the per-key attempt limiter
// used by every module of the block but pkl_checker; no dependencies
package pkl_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		VERDICT_ALLOW    = 2'd0,
		VERDICT_BLOCK    = 2'd1,
		VERDICT_THROTTLE = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		REG_PROTECT_ENABLE  = 3'd0,
		REG_ATTEMPT_LIMIT   = 3'd1,
		REG_WINDOW_SECONDS  = 3'd2,
		REG_ACTION_MODE     = 3'd3,
		REG_THROTTLE_MILLIS = 3'd4
	} reg_idx_t;

	localparam logic [15:0] LIMIT_RST    = 16'd5;
	localparam logic [31:0] WINDOW_RST   = 32'd300;
	localparam logic [31:0] THROTTLE_RST = 32'd1000;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	typedef struct packed {
		logic        protect_enable;
		logic [15:0] attempt_limit;
		logic [31:0] window_seconds;
		logic        action_mode;
		logic [31:0] throttle_millis;
	} cfg_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] count;
		logic [31:0] start;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_en;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_ready;
	} dp_sts_t;

endpackage

[design/pkl_regs.sv]
// pkl_regs: configuration register file behind the apb-style port
// depends on pkl_pkg
module pkl_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pkl_pkg::ADDR_W-1:0]  paddr,
	input  logic [pkl_pkg::DATA_W-1:0]  pwdata,
	output logic [pkl_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pkl_pkg::cfg_t               cfg
);

	pkl_pkg::cfg_t    cfg_q;
	pkl_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = pkl_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protect_enable  <= 1'b0;
			cfg_q.attempt_limit   <= pkl_pkg::LIMIT_RST;
			cfg_q.window_seconds  <= pkl_pkg::WINDOW_RST;
			cfg_q.action_mode     <= 1'b0;
			cfg_q.throttle_millis <= pkl_pkg::THROTTLE_RST;
		end else if (wr_en) begin
			unique case (idx)
				pkl_pkg::REG_PROTECT_ENABLE:  cfg_q.protect_enable  <= pwdata[0];
				pkl_pkg::REG_ATTEMPT_LIMIT:   cfg_q.attempt_limit   <= pwdata[15:0];
				pkl_pkg::REG_WINDOW_SECONDS:  cfg_q.window_seconds  <= pwdata;
				pkl_pkg::REG_ACTION_MODE:     cfg_q.action_mode     <= pwdata[0];
				pkl_pkg::REG_THROTTLE_MILLIS: cfg_q.throttle_millis <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pkl_pkg::REG_PROTECT_ENABLE:  prdata = {31'd0, cfg_q.protect_enable};
			pkl_pkg::REG_ATTEMPT_LIMIT:   prdata = {16'd0, cfg_q.attempt_limit};
			pkl_pkg::REG_WINDOW_SECONDS:  prdata = cfg_q.window_seconds;
			pkl_pkg::REG_ACTION_MODE:     prdata = {31'd0, cfg_q.action_mode};
			pkl_pkg::REG_THROTTLE_MILLIS: prdata = cfg_q.throttle_millis;
			default:                      prdata = '0;
		endcase
	end

endmodule

[design/pkl_ctrl.sv]
// pkl_ctrl: sequencing state machine for load, table scan and commit of one attempt
// depends on pkl_pkg
module pkl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              protect_enable,
	input  pkl_pkg::dp_sts_t  sts,
	output pkl_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = protect_enable ? ST_SCAN : ST_EVAL;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (sts.out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

[design/pkl_datapath.sv]
// pkl_datapath: key table memory, fill count, sequential lookup, update and result register
// depends on pkl_pkg
module pkl_datapath #(
	parameter int TABLE_ENTRIES = pkl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pkl_pkg::cfg_t     cfg,
	input  pkl_pkg::dp_cmd_t  cmd,
	output pkl_pkg::dp_sts_t  sts,
	input  logic [31:0]       client_key,
	input  logic [31:0]       now_seconds,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        verdict,
	output logic [31:0]       delay_millis,
	output logic              table_full
);

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CNT_W  = (FILL_W > IDX_W) ? FILL_W : IDX_W;
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

	pkl_pkg::entry_t mem [TABLE_ENTRIES];

	logic [31:0]       key_q, now_q;
	logic              bypass_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rv_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	pkl_pkg::entry_t   rdata_s1;
	logic              hit_q;

	logic              match, issue;
	logic [31:0]       age;
	logic              in_win, over;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	pkl_pkg::entry_t   wr_data;
	logic              fill_inc;
	pkl_pkg::verdict_t vd;
	logic [31:0]       dly;
	logic              full;

	logic              out_valid_q, table_full_q;
	logic [1:0]        verdict_q;
	logic [31:0]       delay_q;

	assign match = cmd.scan_en && rv_s1 && (rdata_s1.key == key_q);
	assign issue = cmd.scan_en && !hit_q && !match &&
		(rd_cnt_q < CNT_W'(fill_q));

	assign sts.scan_done = hit_q || (!rv_s1 && (rd_cnt_q >= CNT_W'(fill_q)));
	assign sts.out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			rv_s1    <= 1'b0;
			hit_q    <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (cmd.load) begin
				rd_cnt_q <= '0;
				rv_s1    <= 1'b0;
				hit_q    <= 1'b0;
			end else if (cmd.scan_en) begin
				rv_s1 <= issue;
				if (issue) rd_cnt_q <= rd_cnt_q + 1'b1;
				if (match) hit_q <= 1'b1;
			end
			if (fill_inc) fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= client_key;
			now_q    <= now_seconds;
			bypass_q <= !cfg.protect_enable;
		end
		if (issue) begin
			rdata_s1  <= mem[rd_cnt_q[IDX_W-1:0]];
			rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (wr_en) mem[wr_idx] <= wr_data;
	end

	// window test, verdict and table-full flag, and update of the hit entry or insert of a new one
	always_comb begin
		age      = now_q - rdata_s1.start;
		in_win   = age < cfg.window_seconds;
		over     = rdata_s1.count >= cfg.attempt_limit;
		wr_en    = 1'b0;
		wr_idx   = rd_idx_s1;
		wr_data  = rdata_s1;
		fill_inc = 1'b0;
		vd       = pkl_pkg::VERDICT_ALLOW;
		dly      = '0;
		full     = 1'b0;
		priority if (bypass_q) begin
			vd = pkl_pkg::VERDICT_ALLOW;
		end else if (hit_q) begin
			if (in_win && over) begin
				if (cfg.action_mode) begin
					vd  = pkl_pkg::VERDICT_THROTTLE;
					dly = cfg.throttle_millis;
				end else begin
					vd = pkl_pkg::VERDICT_BLOCK;
				end
			end else begin
				wr_en = cmd.commit;
				if (in_win) begin
					if (rdata_s1.count != pkl_pkg::COUNT_MAX)
						wr_data.count = rdata_s1.count + 16'd1;
				end else begin
					wr_data.count = 16'd1;
					wr_data.start = now_q;
				end
			end
		end else if (fill_q == FILL_MAX) begin
			full = 1'b1;
		end else begin
			wr_en         = cmd.commit;
			fill_inc      = cmd.commit;
			wr_idx        = fill_q[IDX_W-1:0];
			wr_data.key   = key_q;
			wr_data.count = 16'd1;
			wr_data.start = now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q    <= vd;
			delay_q      <= dly;
			table_full_q <= full;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign delay_millis = delay_q;
	assign table_full   = table_full_q;

endmodule

[design/per_key_failed_attempt_limiter.sv]
// per_key_failed_attempt_limiter: top level joining config registers, controller, datapath
// depends on pkl_pkg, pkl_regs, pkl_ctrl, pkl_datapath
//
// Usage:
//   Input channel (in_valid/in_stall) carries one login attempt per beat:
//   client_key and now_seconds. Output channel (out_valid/out_stall) carries
//   one result beat per attempt: verdict, delay_millis, table_full.
//   Registers are to be written over the apb-style port only while the block
//   is idle; the block itself does not enforce this. With protection off a
//   load goes straight to the evaluate state with no table scan.
//   With protection on the table is searched one entry per cycle through the
//   single read port of the entry memory, up to the number of stored keys F;
//   the scan ends early when the key is found. The next attempt is taken the
//   cycle after the result is written to the output register.
//   A result waiting under out_stall stays in the output register; the block
//   still takes the next attempt and holds it before its commit until the
//   output register is free.
//   Reset clears the registers to their defaults and empties the table
//   (fill count zero); no clearing pass is needed.
module per_key_failed_attempt_limiter #(
	parameter int TABLE_ENTRIES = pkl_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pkl_pkg::ADDR_W-1:0]  paddr,
	input  logic [pkl_pkg::DATA_W-1:0]  pwdata,
	output logic [pkl_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 client_key,
	input  logic [31:0]                 now_seconds,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  verdict,
	output logic [31:0]                 delay_millis,
	output logic                        table_full
);

	pkl_pkg::cfg_t    cfg;
	pkl_pkg::dp_cmd_t cmd;
	pkl_pkg::dp_sts_t sts;

	pkl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pkl_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.protect_enable (cfg.protect_enable),
		.sts            (sts),
		.cmd            (cmd)
	);

	pkl_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.client_key   (client_key),
		.now_seconds  (now_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.delay_millis (delay_millis),
		.table_full   (table_full)
	);

endmodule

[design/pkl_checker.sv]
// pkl_checker: port-level assertions for the attempt limiter, bound to the top level
// depends on per_key_failed_attempt_limiter
module pkl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  verdict,
	input logic [31:0]                 delay_millis,
	input logic                        table_full
);

	// an accepted beat makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) &&
		$stable(delay_millis) && $stable(table_full))
		else $error("stalled result beat changed");

	// a new result only comes out of a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without work in flight");

	// finishing an attempt always leaves a result
	a_done_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("attempt finished without result beat");

endmodule

bind per_key_failed_attempt_limiter pkl_checker u_pkl_checker (.*);

[sim/pkl_verdict_checker.sv]
// pkl_verdict_checker: watches the register, attempt and result ports of the limiter,
// predicts each verdict from its own copy of the key table and counts mismatches
// depends on pkl_pkg
module pkl_verdict_checker import pkl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [31:0]       client_key,
	input  logic [31:0]       now_seconds,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        verdict,
	input  logic [31:0]       delay_millis,
	input  logic              table_full,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = TABLE_ENTRIES_DEF;

	typedef struct {
		logic [31:0] key;
		logic [31:0] at;
		verdict_t    verdict;
		logic [31:0] delay;
		logic        full;
	} attempt_result_t;

	cfg_t            cfg;
	bit              slot_used [SLOTS];
	entry_t          slot [SLOTS];
	attempt_result_t pending_verdicts [$];

	function automatic attempt_result_t judge_attempt(logic [31:0] key, logic [31:0] at);
		attempt_result_t r;
		int hit;
		int spare;
		logic [31:0] age;
		hit = -1;
		spare = -1;
		r.key = key;
		r.at = at;
		r.verdict = VERDICT_ALLOW;
		r.delay = '0;
		r.full = 1'b0;
		if (!cfg.protect_enable)
			return r;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i]) begin
				if (hit < 0 && slot[i].key == key)
					hit = i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (hit >= 0) begin
			age = at - slot[hit].start;
			if (age < cfg.window_seconds) begin
				if (slot[hit].count >= cfg.attempt_limit) begin
					if (cfg.action_mode) begin
						r.verdict = VERDICT_THROTTLE;
						r.delay = cfg.throttle_millis;
					end else begin
						r.verdict = VERDICT_BLOCK;
					end
				end else if (slot[hit].count != COUNT_MAX) begin
					slot[hit].count = slot[hit].count + 16'd1;
				end
			end else begin
				slot[hit].count = 16'd1;
				slot[hit].start = at;
			end
		end else if (spare < 0) begin
			r.full = 1'b1;
		end else begin
			slot_used[spare] = 1'b1;
			slot[spare] = '{key: key, count: 16'd1, start: at};
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		attempt_result_t want;
		if (!arst_n) begin
			cfg = '{protect_enable: 1'b0, attempt_limit: LIMIT_RST,
				window_seconds: WINDOW_RST, action_mode: 1'b0,
				throttle_millis: THROTTLE_RST};
			foreach (slot_used[i])
				slot_used[i] = 1'b0;
			pending_verdicts.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_PROTECT_ENABLE:  cfg.protect_enable  = pwdata[0];
				REG_ATTEMPT_LIMIT:   cfg.attempt_limit   = pwdata[15:0];
				REG_WINDOW_SECONDS:  cfg.window_seconds  = pwdata;
				REG_ACTION_MODE:     cfg.action_mode     = pwdata[0];
				REG_THROTTLE_MILLIS: cfg.throttle_millis = pwdata;
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: verdict %0d delay %h full %b",
							verdict, delay_millis, table_full);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict !== want.verdict || delay_millis !== want.delay ||
						table_full !== want.full) begin
						if (mismatches < 10)
							$display("mismatch key %h at %h: exp %0d/%h/%b, got %0d/%h/%b",
								want.key, want.at, want.verdict, want.delay, want.full,
								verdict, delay_millis, table_full);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_verdicts.push_back(judge_attempt(client_key, now_seconds));
			outstanding = pending_verdicts.size();
		end
	end

endmodule

[sim/per_key_failed_attempt_limiter_tb.sv]
// per_key_failed_attempt_limiter_tb: drives login attempts, register writes and output
// stalls into the limiter and reports the verdict; depends on pkl_pkg, the limiter
// and pkl_verdict_checker
module per_key_failed_attempt_limiter_tb import pkl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [31:0]       client_key = '0;
	logic [31:0]       now_seconds = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        verdict;
	logic [31:0]       delay_millis;
	logic              table_full;
	int                mismatches;
	int                outstanding;

	int                burst_left = 0;
	bit                hold_off_req = 1'b0;
	logic [31:0]       seen_keys [$];
	logic [31:0]       wall_clock;

	per_key_failed_attempt_limiter DUT (.*);

	pkl_verdict_checker u_checker (.*);

	always #2 clk = ~clk;

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic pe, input logic [15:0] lim, input logic [31:0] win,
		input logic act, input logic [31:0] thr);
		write_reg(REG_PROTECT_ENABLE, {31'd0, pe});
		write_reg(REG_ATTEMPT_LIMIT, {16'd0, lim});
		write_reg(REG_WINDOW_SECONDS, win);
		write_reg(REG_ACTION_MODE, {31'd0, act});
		write_reg(REG_THROTTLE_MILLIS, thr);
	endtask

	task automatic offer(input logic [31:0] key, input logic [31:0] stamp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		client_key <= key;
		now_seconds <= stamp;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
	endtask

	// receiver: free stretches, random stalls, solid stalls, one long hold-off on request
	initial begin : receiver
		int span;
		int style;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (250) @(posedge clk);
			end else begin
				style = $urandom_range(0, 9);
				span = $urandom_range(1, 40);
				repeat (span) begin
					case (style)
					0, 1, 2, 3: out_stall <= 1'b0;
					4, 5, 6, 7: out_stall <= ($urandom_range(0, 2) == 0);
					8: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'b1;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		logic [31:0] key;
		logic [31:0] stamp;
		logic [31:0] win;
		logic [31:0] thr;
		logic [15:0] lim;
		int pick;
		int recent;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// protection off out of reset
		offer(32'h0000_0000, 32'h0000_0000);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// block mode, window wraps across zero
		set_config(1'b1, 16'd2, 32'd100, 1'b0, 32'd1000);
		offer(32'h0000_0000, 32'hFFFF_FFF0);
		offer(32'h0000_0000, 32'h0000_0005);
		offer(32'h0000_0000, 32'h0000_000A);
		offer(32'h0000_0000, 32'h0000_0054);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// throttle mode, largest delay
		set_config(1'b1, 16'd2, 32'd100, 1'b1, 32'hFFFF_FFFF);
		offer(32'h0000_0000, 32'h0000_0055);
		offer(32'h0000_0000, 32'h0000_0056);
		offer(32'hFFFF_FFFF, 32'h0000_0062);
		drain();

		// limit zero, widest window
		set_config(1'b1, 16'd0, 32'hFFFF_FFFF, 1'b1, 32'd0);
		offer(32'h0000_0000, 32'h0000_0057);
		offer(32'h1234_5678, 32'h0000_0007);
		offer(32'h1234_5678, 32'h0000_0007);
		drain();

		// zero window always expires, largest limit
		set_config(1'b1, 16'hFFFF, 32'd0, 1'b0, 32'd1000);
		offer(32'h0000_0000, 32'h0000_0057);
		offer(32'h0000_0000, 32'h0000_0057);
		offer(32'h1234_5678, 32'h0000_0000);
		drain();

		// protection off with a populated table
		set_config(1'b0, 16'd5, 32'd300, 1'b0, 32'd1000);
		offer(32'h0000_0000, 32'h0000_0057);
		offer(32'hA5A5_A5A5, 32'h5A5A_5A5A);
		drain();

		seen_keys.push_back(32'h0000_0000);
		seen_keys.push_back(32'hFFFF_FFFF);
		seen_keys.push_back(32'h1234_5678);
		wall_clock = 32'h0000_1000;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 5))
			0: lim = 16'd0;
			1: lim = 16'hFFFF;
			default: lim = 16'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 5))
			0: win = 32'd0;
			1: win = 32'hFFFF_FFFF;
			2: win = $urandom;
			default: win = $urandom_range(5, 80);
			endcase
			case ($urandom_range(0, 3))
			0: thr = 32'd0;
			1: thr = 32'hFFFF_FFFF;
			default: thr = $urandom;
			endcase
			set_config(phase != 3, lim, win, 1'($urandom_range(0, 1)), thr);
			if (phase == 1)
				hold_off_req = 1'b1;
			for (int n = 0; n < 50; n++) begin
				pick = $urandom_range(0, 99);
				recent = (seen_keys.size() < 6) ? seen_keys.size() : 6;
				if (pick < ((phase == 7) ? 50 : 25)) begin
					key = $urandom;
					seen_keys.push_back(key);
				end else if (pick < 75) begin
					key = seen_keys[seen_keys.size() - 1 - $urandom_range(0, recent - 1)];
				end else begin
					key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
				end
				case ($urandom_range(0, 19))
				0: stamp = $urandom;
				1: begin
					wall_clock += $urandom;
					stamp = wall_clock;
				end
				default: begin
					wall_clock += $urandom_range(0, 12);
					stamp = wall_clock;
				end
				endcase
				offer(key, stamp);
				if (phase == 2 && n == 25)
					drain();
			end
			drain();
		end

		repeat (80) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("per_key_failed_attempt_limiter_tb: done, clean");
		else
			$display("per_key_failed_attempt_limiter_tb: done, errors");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("per_key_failed_attempt_limiter_tb: done, errors");
		$finish;
	end

endmodule
